/* rtl/tqsb_pkg.sv */
// ----------------------------------------------------------------------------
// tqsb_pkg: shared definitions for the two-queue shared buffer
// Operation codes, result status codes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tqsb_pkg;

    // Default number of words in the shared store.
    localparam int DEPTH_DEF = 16;

    // Word and field widths.
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_A = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_B = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_A  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_B  = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW_A = 3'd4;
    localparam logic [OP_W-1:0] OP_SHOW_B = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // What the output register loads in a cycle.
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PUSH,
        OUT_EMPTY,
        OUT_DATA
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     push;
        logic     pop_start;
        logic     show_start;
        logic     show_step;
        out_sel_t out_sel;
        logic     out_last;
    } tqsb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_empty;
        logic            b_empty;
        logic            walk_last;
        logic            out_free;
    } tqsb_stat_t;

endpackage

/* rtl/two_queue_shared_buffer_core.sv */
// ----------------------------------------------------------------------------
// two_queue_shared_buffer_core: two queues in one shared word store
// Queue A fills the store upward from the low end, queue B downward from
// the high end; supports push, pop and show on either queue.
// ----------------------------------------------------------------------------
// The block takes one operation at a time. A push, an unused op code, or a
// pop or show of an empty queue goes from the transfer to the execute
// state only; a pop or show of a nonempty queue then also goes through the
// emit state, since the store has one registered read port; a show delivers
// one element per cycle while the sink keeps tready high. A full output
// register holds the block back only while the sink
// stalls. The next input transfer is taken as soon as the previous
// operation has placed its last result in the output register, even if that
// result has not yet been taken. Queue storage is reclaimed only when a
// queue empties; no clearing pass is needed after reset.
module two_queue_shared_buffer_core
    import tqsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op [2:0], value [34:3], zero [39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status [1:0], data [33:2], zero [39:34]
    output logic        m_tlast
);

    tqsb_cmd_t                cmd;
    tqsb_stat_t               stat;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;

    tqsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tqsb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[2:0]),
        .in_value   (s_tdata[34:3]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .out_data   (data),
        .out_last   (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {6'd0, data, status};

endmodule

/* rtl/tqsb_dp.sv */
// ----------------------------------------------------------------------------
// tqsb_dp: datapath of the two-queue shared buffer
// Holds the input item, the queue pointers, the shared word store, the
// show walk pointer and the output register.
// ----------------------------------------------------------------------------
module tqsb_dp
    import tqsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tqsb_cmd_t                  cmd,
    output tqsb_stat_t                 stat,
    input  logic [OP_W-1:0]            in_op,
    input  logic signed [WORD_W-1:0]   in_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        out_status,
    output logic signed [WORD_W-1:0]   out_data,
    output logic                       out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
    localparam logic [PW-1:0] ONE_P   = PW'(1);

    // Queue A pointers are kept offset by one so that zero marks empty.
    logic [PW-1:0] ha_reg, ha_next;
    logic [PW-1:0] ta_reg, ta_next;
    logic [PW-1:0] hb_reg, hb_next;
    logic [PW-1:0] tb_reg, tb_next;
    logic [AW-1:0] walk_reg, walk_next;

    logic [OP_W-1:0]          op_reg;
    logic signed [WORD_W-1:0] value_reg;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     we;
    logic [AW-1:0]            wr_addr;
    logic                     re;
    logic [AW-1:0]            rd_addr;

    logic                       valid_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic signed [WORD_W-1:0]   data_reg;
    logic                       last_reg;

    logic a_empty, b_empty, full, is_b;
    logic [PW-1:0] ta_inc, tb_dec, ha_inc;
    logic [PW-1:0] walk_ext;

    assign is_b     = op_reg[0];
    assign a_empty  = (ta_reg == '0);
    assign b_empty  = (tb_reg == DEPTH_P);
    assign full     = ((ta_reg) == tb_reg);
    assign ta_inc   = ta_reg + ONE_P;
    assign tb_dec   = tb_reg - ONE_P;
    assign ha_inc   = ha_reg + ONE_P;
    assign walk_ext = {{(PW-AW){1'b0}}, walk_reg};

    // Status toward the controller.
    always_comb
    begin
        stat.op        = op_reg;
        stat.a_empty   = a_empty;
        stat.b_empty   = b_empty;
        stat.walk_last = is_b ? (walk_ext == tb_reg) : ((walk_ext + ONE_P) == ta_reg);
        stat.out_free  = !valid_reg || out_ready;
    end

    // Pointer updates, store write and store read selection.
    always_comb
    begin
        ha_next   = ha_reg;
        ta_next   = ta_reg;
        hb_next   = hb_reg;
        tb_next   = tb_reg;
        walk_next = walk_reg;
        we        = 1'b0;
        wr_addr   = '0;
        re        = 1'b0;
        rd_addr   = '0;
        if (cmd.push && !full)
        begin
            we = 1'b1;
            if (!is_b)
            begin
                ha_next = a_empty ? ONE_P : ha_reg;
                ta_next = a_empty ? ONE_P : ta_inc;
                wr_addr = a_empty ? '0 : ta_reg[AW-1:0];
            end
            else
            begin
                hb_next = b_empty ? (DEPTH_P - ONE_P) : hb_reg;
                tb_next = b_empty ? (DEPTH_P - ONE_P) : tb_dec;
                wr_addr = b_empty ? AW'(DEPTH - 1) : tb_dec[AW-1:0];
            end
        end
        if (cmd.pop_start)
        begin
            re = 1'b1;
            if (!is_b)
            begin
                rd_addr = ha_reg[AW-1:0] - AW'(1);
                if (ha_reg == ta_reg)
                begin
                    ha_next = '0;
                    ta_next = '0;
                end
                else
                begin
                    ha_next = ha_inc;
                end
            end
            else
            begin
                rd_addr = hb_reg[AW-1:0];
                if (hb_reg == tb_reg)
                begin
                    hb_next = DEPTH_P;
                    tb_next = DEPTH_P;
                end
                else
                begin
                    hb_next = hb_reg - ONE_P;
                end
            end
        end
        if (cmd.show_start)
        begin
            re        = 1'b1;
            walk_next = is_b ? hb_reg[AW-1:0] : (ha_reg[AW-1:0] - AW'(1));
            rd_addr   = walk_next;
        end
        if (cmd.show_step)
        begin
            re        = 1'b1;
            walk_next = is_b ? (walk_reg - AW'(1)) : (walk_reg + AW'(1));
            rd_addr   = walk_next;
        end
    end

    // Control registers: pointers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ha_reg    <= '0;
            ta_reg    <= '0;
            hb_reg    <= DEPTH_P;
            tb_reg    <= DEPTH_P;
            valid_reg <= 1'b0;
        end
        else
        begin
            ha_reg <= ha_next;
            ta_reg <= ta_next;
            hb_reg <= hb_next;
            tb_reg <= tb_next;
            if (cmd.out_sel != OUT_NONE)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input item, walk pointer and result.
    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        if (cmd.load_in)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        case (cmd.out_sel)
            OUT_PUSH:
            begin
                status_reg <= full ? ST_FULL : ST_OK;
                data_reg   <= '0;
                last_reg   <= 1'b1;
            end
            OUT_EMPTY:
            begin
                status_reg <= ST_EMPTY;
                data_reg   <= '0;
                last_reg   <= 1'b1;
            end
            OUT_DATA:
            begin
                status_reg <= ST_OK;
                data_reg   <= rd_data_reg;
                last_reg   <= cmd.out_last;
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

    // Shared word store with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_last   = last_reg;

endmodule

/* rtl/tqsb_ctrl.sv */
// ----------------------------------------------------------------------------
// tqsb_ctrl: controller of the two-queue shared buffer
// Sequences one item at a time: latch, execute, then emit store words
// for pops and shows.
// ----------------------------------------------------------------------------
module tqsb_ctrl
    import tqsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tqsb_stat_t stat,
    output tqsb_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   q_empty, is_pop;

    assign q_empty  = stat.op[0] ? stat.b_empty : stat.a_empty;
    assign is_pop   = (stat.op == OP_POP_A) || (stat.op == OP_POP_B);
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_sel    = OUT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.op) inside
                    OP_PUSH_A, OP_PUSH_B:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.push    = 1'b1;
                            cmd.out_sel = OUT_PUSH;
                            state_next  = S_IDLE;
                        end
                    end
                    OP_POP_A, OP_POP_B, OP_SHOW_A, OP_SHOW_B:
                    begin
                        if (q_empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_sel = OUT_EMPTY;
                                state_next  = S_IDLE;
                            end
                        end
                        else if (is_pop)
                        begin
                            cmd.pop_start = 1'b1;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            cmd.show_start = 1'b1;
                            state_next     = S_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_sel  = OUT_DATA;
                    cmd.out_last = is_pop || stat.walk_last;
                    if (is_pop || stat.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.show_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* tb/two_queue_shared_buffer_core_tb.sv */
// ----------------------------------------------------------------------------
// two_queue_shared_buffer_core_tb: self-checking bench for the shared buffer
// Drives push, pop and show operations on both queues through the input
// stream and checks every output transfer against a cycle-free predictor of
// the two queues. A short directed table covers the empty, full and spare
// op code cases first, then random traffic runs with idling on both sides
// and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module two_queue_shared_buffer_core_tb;
    import tqsb_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // Op codes that the block must ignore.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_OPS   = 280;
    localparam int HOLD_AFTER   = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TABLE_ROWS   = 17;

    typedef enum logic {
        CHECK_PREDICTED,
        CHECK_FIXED
    } check_kind_t;

    // One row of the directed table; a row is sent reps times with the
    // value counting up by one on each repeat.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [WORD_W-1:0]   value;
        logic [4:0]          reps;
        check_kind_t         check;
        logic [STATUS_W-1:0] status;
    } step_row_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic                last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // op [2:0], value [34:3], zero [39:35]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // status [1:0], data [33:2], zero [39:34]
    logic        m_tlast;

    // Predicted queue state.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int a_head = -1;
    int a_tail = -1;
    int b_head = DEPTH;
    int b_tail = DEPTH;

    result_t   awaited_results [$];
    step_row_t step_table [TABLE_ROWS];

    int  error_count = 0;
    int  random_sent = 0;
    int  stall_cycles = 0;
    int  src_burst = 0;
    int  sink_idle = 0;
    int  sink_burst = 0;
    bit  hold_done = 1'b0;

    two_queue_shared_buffer_core #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock with a period of ten units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic step_row_t row(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                                      input int reps, input check_kind_t check,
                                      input logic [STATUS_W-1:0] status);
        step_row_t r;
        r.op     = op;
        r.value  = value;
        r.reps   = reps[4:0];
        r.check  = check;
        r.status = status;
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch: %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic note_result(input bit keep, input logic [STATUS_W-1:0] status,
                               input logic [WORD_W-1:0] data, input logic last);
        result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        if (keep)
            awaited_results.push_back(r);
    endtask

    // Applies one accepted operation to the predicted queues and, when keep
    // is set, queues up the results it causes.
    task automatic run_queue_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                                input bit keep);
        bit a_empty;
        bit b_empty;
        a_empty = (a_head == -1) && (a_tail == -1);
        b_empty = (b_head == DEPTH) && (b_tail == DEPTH);
        case (op)
            OP_PUSH_A, OP_PUSH_B:
            begin
                if (a_tail + 1 == b_tail)
                begin
                    note_result(keep, ST_FULL, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_PUSH_A)
                    begin
                        if (a_empty)
                        begin
                            a_head = 0;
                            a_tail = 0;
                        end
                        else
                        begin
                            a_tail++;
                        end
                        shadow_words[a_tail] = value;
                    end
                    else
                    begin
                        if (b_empty)
                        begin
                            b_head = DEPTH - 1;
                            b_tail = DEPTH - 1;
                        end
                        else
                        begin
                            b_tail--;
                        end
                        shadow_words[b_tail] = value;
                    end
                    note_result(keep, ST_OK, '0, 1'b1);
                end
            end
            OP_POP_A:
            begin
                if (a_empty)
                begin
                    note_result(keep, ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    note_result(keep, ST_OK, shadow_words[a_head], 1'b1);
                    a_head++;
                    // The space comes back only once the queue runs dry.
                    if (a_head > a_tail)
                    begin
                        a_head = -1;
                        a_tail = -1;
                    end
                end
            end
            OP_POP_B:
            begin
                if (b_empty)
                begin
                    note_result(keep, ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    note_result(keep, ST_OK, shadow_words[b_head], 1'b1);
                    b_head--;
                    if (b_head < b_tail)
                    begin
                        b_head = DEPTH;
                        b_tail = DEPTH;
                    end
                end
            end
            OP_SHOW_A:
            begin
                if (a_empty)
                    note_result(keep, ST_EMPTY, '0, 1'b1);
                else
                    for (int i = a_head; i <= a_tail; i++)
                        note_result(keep, ST_OK, shadow_words[i], i == a_tail);
            end
            OP_SHOW_B:
            begin
                if (b_empty)
                    note_result(keep, ST_EMPTY, '0, 1'b1);
                else
                    for (int i = b_head; i >= b_tail; i--)
                        note_result(keep, ST_OK, shadow_words[i], i == b_tail);
            end
            default:
            begin
                // Spare op codes leave the state alone and produce nothing.
            end
        endcase
    endtask

    // Offers one operation and waits for its transfer. Fixed rows queue the
    // result typed into the table; the predictor still tracks the state.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                           input bit fixed, input logic [STATUS_W-1:0] fixed_status);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, op};
        do
            @(posedge clk);
        while (!s_tready);
        run_queue_op(op, value, !fixed);
        if (fixed)
            note_result(1'b1, fixed_status, '0, 1'b1);
    endtask

    // Gap after a transfer, with bursts where the sender never idles.
    task automatic pause_source();
        int gap;
        if (src_burst > 0)
        begin
            src_burst--;
            return;
        end
        src_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random operation, weighted toward filling, draining or a mix.
    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        int push_cut;
        r = $urandom_range(0, 99);
        push_cut = (mode == 0) ? 64 : (mode == 1) ? 30 : 45;
        if (r < 4)
            return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
        if (r < push_cut)
            return $urandom_range(0, 1) ? OP_PUSH_B : OP_PUSH_A;
        if (r < 82)
            return $urandom_range(0, 1) ? OP_POP_B : OP_POP_A;
        return $urandom_range(0, 1) ? OP_SHOW_B : OP_SHOW_A;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: reset, directed table, random traffic, then drain.
    initial
    begin
        int mode;
        int mode_left;
        logic [OP_W-1:0] op;

        step_table[0]  = row(OP_POP_A,   32'h0,         1,  CHECK_FIXED,     ST_EMPTY);
        step_table[1]  = row(OP_POP_B,   32'h0,         1,  CHECK_FIXED,     ST_EMPTY);
        step_table[2]  = row(OP_SHOW_A,  32'h0,         1,  CHECK_FIXED,     ST_EMPTY);
        step_table[3]  = row(OP_SHOW_B,  32'h0,         1,  CHECK_FIXED,     ST_EMPTY);
        step_table[4]  = row(OP_SPARE_6, 32'hFFFF_FFFF, 1,  CHECK_PREDICTED, ST_OK);
        step_table[5]  = row(OP_SPARE_7, 32'h0,         1,  CHECK_PREDICTED, ST_OK);
        step_table[6]  = row(OP_PUSH_A,  32'h7FFF_FFFF, 1,  CHECK_FIXED,     ST_OK);
        step_table[7]  = row(OP_PUSH_A,  32'h8000_0000, 1,  CHECK_FIXED,     ST_OK);
        step_table[8]  = row(OP_SHOW_A,  32'h0,         1,  CHECK_PREDICTED, ST_OK);
        step_table[9]  = row(OP_POP_A,   32'h0,         2,  CHECK_PREDICTED, ST_OK);
        // Queue A has just run dry and must report empty again.
        step_table[10] = row(OP_POP_A,   32'h0,         1,  CHECK_FIXED,     ST_EMPTY);
        // Queue B takes the whole store, values wrapping through zero.
        step_table[11] = row(OP_PUSH_B,  32'hFFFF_FFFF, 16, CHECK_PREDICTED, ST_OK);
        step_table[12] = row(OP_PUSH_A,  32'h1234_5678, 1,  CHECK_FIXED,     ST_FULL);
        step_table[13] = row(OP_PUSH_B,  32'h8765_4321, 1,  CHECK_FIXED,     ST_FULL);
        step_table[14] = row(OP_SHOW_B,  32'h0,         1,  CHECK_PREDICTED, ST_OK);
        step_table[15] = row(OP_POP_B,   32'h0,         2,  CHECK_PREDICTED, ST_OK);
        step_table[16] = row(OP_SHOW_B,  32'h0,         1,  CHECK_PREDICTED, ST_OK);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            for (int k = 0; k < step_table[r].reps; k++)
            begin
                send_op(step_table[r].op, step_table[r].value + k,
                        step_table[r].check == CHECK_FIXED, step_table[r].status);
                pause_source();
            end
        end

        mode_left = 0;
        mode = 2;
        while (random_sent < RANDOM_OPS)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 48);
            end
            mode_left--;
            op = pick_op(mode);
            send_op(op, pick_value(), 1'b0, ST_OK);
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                random_sent++;
            pause_source();
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random idling, calm bursts, and one long hold-off once the
    // random traffic is under way so the block backs up into its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && random_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                sink_idle = HOLD_CYCLES;
            end
            if (sink_idle > 0)
            begin
                sink_idle--;
                m_tready <= 1'b0;
            end
            else if (sink_burst > 0)
            begin
                sink_burst--;
                m_tready <= 1'b1;
            end
            else
            begin
                sink_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 6);
                sink_idle = pick_gap();
                m_tready <= (sink_idle == 0);
            end
        end
    end

    // Output check against the oldest awaited result.
    always @(posedge clk)
    begin : check_output
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with none awaited", m_tdata[33:2], '0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", WORD_W'(m_tdata[1:0]), WORD_W'(want.status));
                if (m_tdata[33:2] != want.data)
                    report_mismatch("data", m_tdata[33:2], want.data);
                if (m_tlast != want.last)
                    report_mismatch("last", WORD_W'(m_tlast), WORD_W'(want.last));
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
